// ===== hdl/cfsh32_pkg.sv =====
package cfsh32_pkg;

  localparam logic [31:0] HashMult = 32'hB3CB2E29;
  localparam logic [31:0] HashSeed = 32'h319712C3;

  localparam logic [7:0] CharNul   = 8'd0;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;
  localparam logic [7:0] CharUpA   = 8'd65;
  localparam logic [7:0] CharUpF   = 8'd70;
  localparam logic [7:0] CharUpZ   = 8'd90;
  localparam logic [7:0] CharLowA  = 8'd97;
  localparam logic [7:0] CharLowF  = 8'd102;
  localparam logic [7:0] CharLowX  = 8'd120;
  localparam logic [7:0] CaseDelta = 8'd32;

  // where the next byte falls in the name
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_LATER  = 2'd2
  } pos_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  // A-Z to lower case, high bytes sign-extended
  function automatic logic [31:0] fold_byte(input logic [7:0] b);
    logic [31:0] r;
    if (b >= CharUpA && b <= CharUpZ) begin
      r = {24'd0, b + CaseDelta};
    end else if (b[7]) begin
      r = {24'hFFFFFF, b};
    end else begin
      r = {24'd0, b};
    end
    return r;
  endfunction

  function automatic hex_digit_t hex_digit(input logic [7:0] b);
    hex_digit_t r;
    logic [7:0] diff;
    r    = '0;
    diff = '0;
    if (b >= CharZero && b <= CharNine) begin
      diff = b - CharZero;
      r.ok = 1'b1;
    end else if (b >= CharLowA && b <= CharLowF) begin
      diff = b - CharLowA + 8'd10;
      r.ok = 1'b1;
    end else if (b >= CharUpA && b <= CharUpF) begin
      diff = b - CharUpA + 8'd10;
      r.ok = 1'b1;
    end
    r.val = diff[3:0];
    return r;
  endfunction

endpackage

// ===== hdl/case_folded_string_hash32_top.sv =====
// Case-folded xor-multiply string hash over a NUL-terminated name.
// Input channel: one name byte per beat (in_valid_i / in_stall_o / name_byte_i).
// Output channel: one result beat per name, sent when the NUL byte is processed
// (out_valid_o / out_stall_i / hash_value_o / was_hex_literal_o).
// A name starting with "0x" yields its hex value (saturating) and was_hex_literal_o.
// Throughput: one byte per cycle, except while a NUL waits for the result register.
// A byte is captured in an input register; from there one 32x32 constant multiply
// (low half) plus xor updates the running hash and, on NUL, loads the result
// register. The result of a name passes through the input register and the result
// register before it is visible on the output. The loop through the hash register
// and the multiplier sets the pace of the byte steps. When out_stall_i holds a
// result, the byte in the input register waits only if it is a NUL; other bytes
// keep flowing. in_stall_o rises only while a NUL waits for the result register to free up.
// Reset (rst_ni low, asynchronous) empties both registers and clears the hash,
// hex and position state, so the next byte is taken as the first of a name.
module case_folded_string_hash32_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  name_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o,
  output logic        was_hex_literal_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;

  // name state
  logic [31:0]       hash_acc_q, hash_acc_d;
  logic [31:0]       hex_acc_q, hex_acc_d;
  cfsh32_pkg::pos_e  pos_q, pos_d;
  logic              first_zero_q, first_zero_d;
  logic              hex_mode_q, hex_mode_d;
  logic              hex_stopped_q, hex_stopped_d;
  logic              hex_sat_q, hex_sat_d;

  // result register
  logic        out_valid_q;
  logic [31:0] hash_value_q, hash_value_d;
  logic        was_hex_q, was_hex_d;

  logic                   emit;
  logic                   out_free;
  logic                   advance;
  logic                   in_fire;
  logic [31:0]            folded;
  logic [31:0]            mul_op;
  logic [31:0]            mul_res;
  cfsh32_pkg::hex_digit_t digit;

  assign folded   = cfsh32_pkg::fold_byte(byte_q);
  assign digit    = cfsh32_pkg::hex_digit(byte_q);
  assign mul_op   = (pos_q == cfsh32_pkg::POS_FIRST) ? (folded ^ cfsh32_pkg::HashSeed)
                                                      : (hash_acc_q ^ folded);
  assign mul_res  = mul_op * cfsh32_pkg::HashMult;

  assign emit     = (byte_q == cfsh32_pkg::CharNul);
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire  = in_valid_i && !in_stall_o;

  always_comb begin
    hash_acc_d    = hash_acc_q;
    hex_acc_d     = hex_acc_q;
    pos_d         = pos_q;
    first_zero_d  = first_zero_q;
    hex_mode_d    = hex_mode_q;
    hex_stopped_d = hex_stopped_q;
    hex_sat_d     = hex_sat_q;
    hash_value_d  = hash_value_q;
    was_hex_d     = was_hex_q;

    if (hex_mode_q) begin
      hash_value_d = hex_acc_q;
      was_hex_d    = 1'b1;
      if (!emit && !hex_stopped_q) begin
        if (!digit.ok) begin
          hex_stopped_d = 1'b1;
        end else if (!hex_sat_q) begin
          if (hex_acc_q[31:28] != 4'd0) begin
            hex_acc_d = '1;
            hex_sat_d = 1'b1;
          end else begin
            hex_acc_d = {hex_acc_q[27:0], digit.val};
          end
        end
      end
    end else if (pos_q == cfsh32_pkg::POS_SECOND && first_zero_q
                 && byte_q == cfsh32_pkg::CharLowX) begin
      // "0x" prefix: drop the tentative hash
      hex_mode_d = 1'b1;
      hash_acc_d = '0;
      pos_d      = cfsh32_pkg::POS_LATER;
    end else begin
      hash_acc_d   = mul_res;
      hash_value_d = mul_res;
      was_hex_d    = 1'b0;
      if (pos_q == cfsh32_pkg::POS_FIRST) begin
        first_zero_d = (byte_q == cfsh32_pkg::CharZero);
        pos_d        = cfsh32_pkg::POS_SECOND;
      end else begin
        pos_d = cfsh32_pkg::POS_LATER;
      end
    end

    if (emit) begin
      hash_acc_d    = '0;
      hex_acc_d     = '0;
      pos_d         = cfsh32_pkg::POS_FIRST;
      first_zero_d  = 1'b0;
      hex_mode_d    = 1'b0;
      hex_stopped_d = 1'b0;
      hex_sat_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      hash_acc_q    <= '0;
      hex_acc_q     <= '0;
      pos_q         <= cfsh32_pkg::POS_FIRST;
      first_zero_q  <= 1'b0;
      hex_mode_q    <= 1'b0;
      hex_stopped_q <= 1'b0;
      hex_sat_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        hash_acc_q    <= hash_acc_d;
        hex_acc_q     <= hex_acc_d;
        pos_q         <= pos_d;
        first_zero_q  <= first_zero_d;
        hex_mode_q    <= hex_mode_d;
        hex_stopped_q <= hex_stopped_d;
        hex_sat_q     <= hex_sat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= name_byte_i;
    end
    if (advance && emit) begin
      hash_value_q <= hash_value_d;
      was_hex_q    <= was_hex_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hash_value_o      = hash_value_q;
  assign was_hex_literal_o = was_hex_q;

  a_hex_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_mode_q |-> pos_q == cfsh32_pkg::POS_LATER)
    else $error("hex mode outside later position");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_sat_q |-> hex_acc_q == 32'hFFFFFFFF)
    else $error("saturated hex value not all ones");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && emit && out_valid_q)
    else $error("input stalled without a waiting NUL");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> out_valid_q && pos_q == cfsh32_pkg::POS_FIRST && !hex_mode_q)
    else $error("state not cleared after result");

endmodule
